// ===== sv/mpeg_audio_header_finder_defines.svh =====
// Assertion macros shared by the header finder RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef MPEG_AUDIO_HEADER_FINDER_DEFINES_SVH
`define MPEG_AUDIO_HEADER_FINDER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MAHF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define MAHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MAHF_ASSERT(lbl, clk, rstn, prop, msg)
`define MAHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/mahf_pkg.sv =====
// Types, constants and table functions for the MPEG audio header finder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mahf_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] SYNC_MASK  = 8'hE0;
    localparam logic [7:0] SIZE_MASK  = 8'h7F;
    localparam logic [7:0] TAG_CHAR_I = 8'h49;
    localparam logic [7:0] TAG_CHAR_D = 8'h44;
    localparam logic [7:0] TAG_CHAR_3 = 8'h33;

    localparam int TAG_LEN_W   = 28;
    localparam int TAG_POS     = 2;   // offset of the last tag id char
    localparam int SIZE_POS    = 9;   // offset of the last size byte
    localparam int HDR_MIN_POS = 3;   // earliest offset a header can end at
    localparam int TAG_SKIP    = 13;  // tag header length plus three

    localparam logic [1:0] VER_25  = 2'd0;
    localparam logic [1:0] VER_RSV = 2'd1;
    localparam logic [1:0] VER_2   = 2'd2;
    localparam logic [1:0] VER_1   = 2'd3;

    localparam logic [1:0] LAY_RSV = 2'd0;
    localparam logic [1:0] LAY_3   = 2'd1;
    localparam logic [1:0] LAY_2   = 2'd2;
    localparam logic [1:0] LAY_1   = 2'd3;

    localparam logic [1:0] VCODE_1  = 2'd0;
    localparam logic [1:0] VCODE_2  = 2'd1;
    localparam logic [1:0] VCODE_25 = 2'd2;

    localparam logic [3:0] BRI_FREE = 4'd0;
    localparam logic [3:0] BRI_BAD  = 4'd15;
    localparam logic [1:0] SRI_RSV  = 2'd3;

    localparam logic [8:0] BR_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
        9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [8:0] BR_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] BR_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
        9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] BR_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [8:0] BR_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
        9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    localparam logic [15:0] RATE_44K = 16'd44100;
    localparam logic [15:0] RATE_48K = 16'd48000;
    localparam logic [15:0] RATE_32K = 16'd32000;

    // header bytes 1..3; byte 0 is the sync byte
    typedef struct packed {
        logic       found;
        logic [23:0] header;
    } hdr_sel_t;

    // lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]  channel_mode;
        logic [15:0] sample_rate_hz;
        logic [8:0]  bitrate_kbps;
        logic [1:0]  layer_number;
        logic [1:0]  mpeg_version;
        logic        found;
    } result_t;

    function automatic logic hdr_ok(input logic [23:0] h);
        logic [1:0] ver;
        logic [1:0] lay;
        logic [3:0] bri;
        logic [1:0] sri;
        ver = h[20:19];
        lay = h[18:17];
        bri = h[15:12];
        sri = h[11:10];
        return ((h[23:16] & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSV)
            && (lay != LAY_RSV) && (bri != BRI_FREE) && (bri != BRI_BAD)
            && (sri != SRI_RSV);
    endfunction

    function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                  input logic [1:0] lay,
                                                  input logic [3:0] bri);
        logic [8:0] br;
        if (ver == VER_1) begin
            case (lay)
                LAY_1:   br = BR_V1_L1[bri];
                LAY_2:   br = BR_V1_L2[bri];
                default: br = BR_V1_L3[bri];
            endcase
        end else begin
            br = (lay == LAY_1) ? BR_V2_L1[bri] : BR_V2_L23[bri];
        end
        return br;
    endfunction

    function automatic logic [15:0] base_rate(input logic [1:0] sri);
        logic [15:0] r;
        case (sri)
            2'd0:    r = RATE_44K;
            2'd1:    r = RATE_48K;
            2'd2:    r = RATE_32K;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mpeg_audio_header_finder.sv =====
// m_tvalid rises after a buffer's last byte is accepted and its result passes
// the selection and result registers. Throughput: one byte per cycle while
// s_tready is high; bytes flow while a result waits, up to one more buffer end.
// Reset (rst_n low, asynchronous): scan state and both valid flags clear.
// Top level; depends on mahf_pkg, mahf_scanner, mahf_decode.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_header_finder
    import mahf_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // found, mpeg_version, layer_number,
                                        // bitrate_kbps, sample_rate_hz, channel_mode
);

    logic     sel_valid;
    hdr_sel_t sel;
    logic     dn_ready;
    result_t  res;

    mahf_scanner #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .dn_ready  (dn_ready),
        .sel_valid (sel_valid),
        .sel       (sel)
    );

    mahf_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel_valid (sel_valid),
        .sel       (sel),
        .up_ready  (dn_ready),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = res;

endmodule

`default_nettype wire

// ===== sv/mahf_scanner.sv =====
// Byte-window scanner: tag detection, size decode, both header scanners
// and the selection register. Depends on mahf_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "mpeg_audio_header_finder_defines.svh"

module mahf_scanner
    import mahf_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       dn_ready,
    output logic            sel_valid,
    output hdr_sel_t        sel
);

    localparam int CW = ((POSITION_WIDTH > TAG_LEN_W + 1) ? POSITION_WIDTH : TAG_LEN_W + 1) + 1;

    logic [23:0]               recent_reg,    recent_next;
    logic [POSITION_WIDTH-1:0] pos_reg,       pos_next;
    logic                      tag_reg,       tag_next;
    logic [TAG_LEN_W-1:0]      tag_len_reg,   tag_len_next;
    logic                      early_reg,     early_next;
    logic [23:0]               early_hdr_reg, early_hdr_next;
    logic                      late_reg,      late_next;
    logic [23:0]               late_hdr_reg,  late_hdr_next;
    logic                      sel_valid_reg, sel_valid_next;
    hdr_sel_t                  sel_reg,       sel_next;

    logic                      accept;
    logic [23:0]               window;
    logic                      hdr_hit;
    logic                      past_tag;
    logic [CW-1:0]             tag_end;

    assign in_ready  = !sel_valid_reg || dn_ready;
    assign accept    = in_valid && in_ready;
    assign sel_valid = sel_valid_reg;
    assign sel       = sel_reg;

    always_comb
    begin
        window   = {recent_reg[15:0], data_byte};
        hdr_hit  = (pos_reg >= POSITION_WIDTH'(HDR_MIN_POS))
                   && (recent_reg[23:16] == SYNC_BYTE) && hdr_ok(window);

        tag_next = tag_reg;
        if ((pos_reg == POSITION_WIDTH'(TAG_POS))
            && (recent_reg[15:0] == {TAG_CHAR_I, TAG_CHAR_D})
            && (data_byte == TAG_CHAR_3))
        begin
            tag_next = 1'b1;
        end

        tag_len_next = tag_len_reg;
        if ((pos_reg == POSITION_WIDTH'(SIZE_POS)) && tag_reg)
        begin
            tag_len_next = {recent_reg[22:16], recent_reg[14:8],
                            recent_reg[6:0], data_byte[6:0] & SIZE_MASK[6:0]};
        end

        tag_end  = CW'(tag_len_next) + CW'(TAG_SKIP);
        past_tag = tag_next && (CW'(pos_reg) >= tag_end);

        early_next     = early_reg;
        early_hdr_next = early_hdr_reg;
        if (hdr_hit && !early_reg)
        begin
            early_next     = 1'b1;
            early_hdr_next = window;
        end

        late_next     = late_reg;
        late_hdr_next = late_hdr_reg;
        if (hdr_hit && !late_reg && past_tag)
        begin
            late_next     = 1'b1;
            late_hdr_next = window;
        end

        if (past_tag)
        begin
            sel_next.found  = late_next;
            sel_next.header = late_hdr_next;
        end else begin
            sel_next.found  = early_next;
            sel_next.header = early_hdr_next;
        end

        recent_next = window;
        pos_next    = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

        if (last_byte)
        begin
            recent_next    = '0;
            pos_next       = '0;
            tag_next       = 1'b0;
            tag_len_next   = '0;
            early_next     = 1'b0;
            early_hdr_next = '0;
            late_next      = 1'b0;
            late_hdr_next  = '0;
        end

        if (accept && last_byte)
            sel_valid_next = 1'b1;
        else if (dn_ready)
            sel_valid_next = 1'b0;
        else
            sel_valid_next = sel_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg    <= '0;
            pos_reg       <= '0;
            tag_reg       <= 1'b0;
            tag_len_reg   <= '0;
            early_reg     <= 1'b0;
            early_hdr_reg <= '0;
            late_reg      <= 1'b0;
            late_hdr_reg  <= '0;
            sel_valid_reg <= 1'b0;
        end else begin
            sel_valid_reg <= sel_valid_next;
            if (accept)
            begin
                recent_reg    <= recent_next;
                pos_reg       <= pos_next;
                tag_reg       <= tag_next;
                tag_len_reg   <= tag_len_next;
                early_reg     <= early_next;
                early_hdr_reg <= early_hdr_next;
                late_reg      <= late_next;
                late_hdr_reg  <= late_hdr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
            sel_reg <= sel_next;
    end

    `MAHF_ASSERT(a_sel_hdr_ok, clk, rst_n,
        !(sel_valid_reg && sel_reg.found) || hdr_ok(sel_reg.header),
        "selected header is not a valid header")
    `MAHF_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && last_byte,
        pos_reg == '0 && !tag_reg && !early_reg && !late_reg,
        "state not cleared after last byte")
    `MAHF_ASSERT(a_len_needs_tag, clk, rst_n, tag_len_reg == '0 || tag_reg,
        "tag size held without a tag")
    `MAHF_ASSERT(a_late_after_tag, clk, rst_n, !late_reg || tag_reg,
        "late header held without a tag")

endmodule

`default_nettype wire

// ===== sv/mahf_decode.sv =====
// Header decode through the bitrate and rate tables into the result register.
// Depends on mahf_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "mpeg_audio_header_finder_defines.svh"

module mahf_decode
    import mahf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     sel_valid,
    input  wire hdr_sel_t sel,
    output logic          up_ready,
    output logic          res_valid,
    input  wire logic     res_ready,
    output result_t       res
);

    logic    res_valid_reg, res_valid_next;
    result_t res_reg,       res_next;

    logic [1:0] ver;
    logic [1:0] lay;
    logic [3:0] bri;
    logic [1:0] sri;
    logic [1:0] vcode;

    assign up_ready  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        ver = sel.header[20:19];
        lay = sel.header[18:17];
        bri = sel.header[15:12];
        sri = sel.header[11:10];
        case (ver)
            VER_1:   vcode = VCODE_1;
            VER_2:   vcode = VCODE_2;
            default: vcode = VCODE_25;
        endcase

        res_next = '0;
        if (sel.found)
        begin
            res_next.found          = 1'b1;
            res_next.mpeg_version   = vcode;
            res_next.layer_number   = 2'(3'd4 - {1'b0, lay});
            res_next.bitrate_kbps   = bitrate_lookup(ver, lay, bri);
            res_next.sample_rate_hz = base_rate(sri) >> vcode;
            res_next.channel_mode   = sel.header[7:6];
        end

        res_valid_next = up_ready ? sel_valid : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && sel_valid)
            res_reg <= res_next;
    end

    `MAHF_ASSERT(a_found_fields, clk, rst_n,
        !(res_valid_reg && res_reg.found) || (res_reg.bitrate_kbps != 9'd0
            && res_reg.sample_rate_hz != 16'd0 && res_reg.layer_number != 2'd0),
        "found result has a zero field")
    `MAHF_ASSERT(a_empty_zero, clk, rst_n,
        !(res_valid_reg && !res_reg.found) || res_reg == '0,
        "empty result carries data")
    `MAHF_ASSERT(a_vcode_range, clk, rst_n,
        !res_valid_reg || res_reg.mpeg_version != 2'd3,
        "version code out of range")

endmodule

`default_nettype wire
